// ===== sv/depth_row_hole_interpolator_assert.svh =====
// Assertion macros used by the depth row hole interpolator checker
`ifndef DEPTH_ROW_HOLE_INTERPOLATOR_ASSERT_SVH
`define DEPTH_ROW_HOLE_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define DRHI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define DRHI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/drhi_pkg.sv =====
// Package: widths, types and constants of the depth row hole interpolator
`timescale 1ns / 1ps

package drhi_pkg;

    // field widths
    localparam int DEPTH_W   = 16;
    localparam int STEP_W    = 33;
    localparam int CNT_W     = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    // hole counter saturates at the smaller of the row width and this
    localparam int CNT_MAX = 2047;
    localparam int MAX_ROW_WIDTH_DEF = 1024;

    // divider: 32-bit dividend, four quotient bits per cycle
    localparam int NUM_W        = 32;
    localparam int DIV_BITS_CYC = 4;
    localparam int FRAC_W       = 16;

    // output tuser bit positions
    localparam int TUSER_HOLE  = 0;
    localparam int TUSER_RDONE = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_HOLE,
        S_PIX,
        S_HEND
    } t_state;

    // which run the output register loads
    typedef enum logic [1:0] {
        LD_NONE,
        LD_HOLE_END,
        LD_HOLE,
        LD_PIX
    } t_load;

    typedef struct packed {
        logic  accept;
        logic  div_start;
        t_load load;
    } t_cmd;

    typedef struct packed {
        logic in_zero;
        logic in_rend;
        logic hole_nz;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ===== sv/depth_row_hole_interpolator.sv =====
// Top level of the depth row hole interpolator
`timescale 1ns / 1ps

// Takes depth pixels (mm, 0 = invalid) in row order and emits runs: each run
// of invalid pixels becomes one hole run (start, signed Q17.16 step, length),
// followed by the valid pixel that closes it, if any, as a one-long run. An
// invalid pixel that does not end a row gives no word. For a valid pixel
// closing a hole, the step comes from an iterative divider that resolves four
// quotient bits per cycle over a 32-bit dividend. The output register lets
// the next pixel be taken while the last word still waits; a stalled output
// adds its stall.
module depth_row_hole_interpolator
    import drhi_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [15:0] depth_mm
    input  logic                 s_axis_tlast,  // row_end
    input  logic                 s_axis_tuser,  // frame_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] run_start, [48:16] run_step, [59:49] run_length, [63:60] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [M_TUSER_W-1:0] m_axis_tuser,  // [0] run_is_hole, [1] row_done
    output logic                 m_axis_tlast   // last
);

    t_cmd    w_cmd;
    t_status w_status;

    drhi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    drhi_dp #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

// ===== sv/drhi_div.sv =====
// Iterative restoring divider, four quotient bits per cycle, signed result
`timescale 1ns / 1ps

module drhi_div
    import drhi_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [NUM_W-1:0]        i_num,
    input  logic                    i_neg,
    input  logic [CNT_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [STEP_W-1:0] o_quot
);

    localparam int DIV_CYC = NUM_W / DIV_BITS_CYC;
    localparam int ITER_W  = $clog2(DIV_CYC);
    localparam int REM_W   = CNT_W + 1;

    logic              r_busy;
    logic [ITER_W-1:0] r_iter;
    logic [NUM_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_den;
    logic              r_neg;
    logic [NUM_W-1:0]  n_num;
    logic [REM_W-1:0]  n_rem;
    logic [STEP_W-1:0] w_mag;

    // four restoring steps; the dividend register fills with quotient bits
    always_comb begin
        n_num = r_num;
        n_rem = r_rem;
        for (int k = 0; k < DIV_BITS_CYC; k++) begin
            n_rem = {n_rem[REM_W-2:0], n_num[NUM_W-1]};
            n_num = {n_num[NUM_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= '0;
        end else if (r_busy) begin
            r_iter <= r_iter + 1'b1;
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    // operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_iter == ITER_W'(DIV_CYC - 1));
    assign w_mag  = {1'b0, r_num};
    assign o_quot = r_neg ? $signed(~w_mag + 1'b1) : $signed(w_mag);

endmodule

// ===== sv/drhi_dp.sv =====
// Datapath: neighbour state, hole counter, step divider and output register
`timescale 1ns / 1ps

module drhi_dp
    import drhi_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = MAX_ROW_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tlast,
    input  logic                 i_s_tuser,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic [M_TDATA_W-1:0] o_m_tdata,
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output logic                 o_m_tlast
);

    localparam int HOLE_CAP = (MAX_ROW_WIDTH > CNT_MAX) ? CNT_MAX : MAX_ROW_WIDTH;
    localparam int PAD_W    = M_TDATA_W - DEPTH_W - STEP_W - CNT_W;

    logic [DEPTH_W-1:0] w_in_depth;
    logic [DEPTH_W-1:0] w_left_eff;
    logic [DEPTH_W:0]   w_diff;
    logic [DEPTH_W:0]   w_diff_abs;
    logic               w_div_done;
    logic signed [STEP_W-1:0] w_quot;

    logic [DEPTH_W-1:0] r_left;
    logic               r_left_ok;
    logic [CNT_W-1:0]   r_hole_cnt;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_rend;
    logic               r_fend;

    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_out_start;
    logic signed [STEP_W-1:0] r_out_step;
    logic [CNT_W-1:0]   r_out_len;
    logic               r_out_hole;
    logic               r_out_rdone;
    logic               r_out_last;

    assign w_in_depth = i_s_tdata[DEPTH_W-1:0];

    // status to the controller
    assign o_status.in_zero  = (w_in_depth == '0);
    assign o_status.in_rend  = i_s_tlast | i_s_tuser;
    assign o_status.hole_nz  = (r_hole_cnt != '0);
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_m_tready;

    // signed difference right minus left, taken apart into sign and size
    assign w_left_eff = r_left_ok ? r_left : w_in_depth;
    assign w_diff     = {1'b0, w_in_depth} - {1'b0, w_left_eff};
    assign w_diff_abs = w_diff[DEPTH_W] ? (~w_diff + 1'b1) : w_diff;

    drhi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   ({w_diff_abs[DEPTH_W-1:0], {FRAC_W{1'b0}}}),
        .i_neg   (w_diff[DEPTH_W]),
        .i_den   (r_hole_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // input word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_depth <= w_in_depth;
            r_rend  <= i_s_tlast | i_s_tuser;
            r_fend  <= i_s_tuser;
        end
    end

    // left neighbour and hole counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_left_ok  <= 1'b0;
            r_hole_cnt <= '0;
        end else begin
            if (i_cmd.accept && o_status.in_zero &&
                (r_hole_cnt < CNT_W'(HOLE_CAP))) begin
                r_hole_cnt <= r_hole_cnt + 1'b1;
            end
            unique case (i_cmd.load)
                LD_HOLE_END: begin
                    r_hole_cnt <= '0;
                    if (r_fend) begin
                        r_left    <= '0;
                        r_left_ok <= 1'b0;
                    end
                end
                LD_HOLE: begin
                    r_hole_cnt <= '0;
                end
                LD_PIX: begin
                    r_left    <= r_fend ? '0 : r_depth;
                    r_left_ok <= !r_fend;
                end
                default: begin
                end
            endcase
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load != LD_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.load)
            LD_HOLE_END: begin
                r_out_start <= r_left_ok ? r_left : '0;
                r_out_step  <= '0;
                r_out_len   <= r_hole_cnt;
                r_out_hole  <= 1'b1;
                r_out_rdone <= 1'b1;
                r_out_last  <= 1'b1;
            end
            LD_HOLE: begin
                r_out_start <= r_left_ok ? r_left : r_depth;
                r_out_step  <= w_quot;
                r_out_len   <= r_hole_cnt;
                r_out_hole  <= 1'b1;
                r_out_rdone <= 1'b0;
                r_out_last  <= 1'b0;
            end
            LD_PIX: begin
                r_out_start <= r_depth;
                r_out_step  <= '0;
                r_out_len   <= CNT_W'(1);
                r_out_hole  <= 1'b0;
                r_out_rdone <= r_rend;
                r_out_last  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_len, r_out_step, r_out_start};
    assign o_m_tuser  = {r_out_rdone, r_out_hole};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== sv/drhi_ctrl.sv =====
// Controller: sequences input acceptance, step division and run emission
`timescale 1ns / 1ps

module drhi_ctrl
    import drhi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_s_tready      = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.load      = LD_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.in_zero) begin
                        n_state = i_status.in_rend ? S_HEND : S_IDLE;
                    end else if (i_status.hole_nz) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_PIX;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_HOLE;
                end
            end
            S_HOLE: begin
                if (i_status.out_free) begin
                    o_cmd.load = LD_HOLE;
                    n_state    = S_PIX;
                end
            end
            S_PIX: begin
                if (i_status.out_free) begin
                    o_cmd.load = LD_PIX;
                    n_state    = S_IDLE;
                end
            end
            S_HEND: begin
                if (i_status.out_free) begin
                    o_cmd.load = LD_HOLE_END;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/drhi_chk.sv =====
// Port-level checker for the depth row hole interpolator, bound to the top
`timescale 1ns / 1ps
`include "depth_row_hole_interpolator_assert.svh"

module drhi_chk
    import drhi_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic                 s_axis_tlast,
    input logic                 s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser,
    input logic                 m_axis_tlast
);

    logic w_hole;
    logic w_rdone;
    logic [STEP_W-1:0] w_step;
    logic [CNT_W-1:0]  w_len;

    assign w_hole  = m_axis_tuser[TUSER_HOLE];
    assign w_rdone = m_axis_tuser[TUSER_RDONE];
    assign w_step  = m_axis_tdata[DEPTH_W +: STEP_W];
    assign w_len   = m_axis_tdata[DEPTH_W+STEP_W +: CNT_W];

    // a stalled word holds
    `DRHI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

    // an original pixel is a flat one-long run closing its input's burst
    `DRHI_ASSERT_NOW(a_pix_run, i_clk, i_rst_n, m_axis_tvalid && !w_hole, (w_len == CNT_W'(1)) && (w_step == '0) && m_axis_tlast, "pixel run malformed")

    // a hole run ending a row is flat and is the last word of its input
    `DRHI_ASSERT_NOW(a_hole_end, i_clk, i_rst_n, m_axis_tvalid && w_hole && w_rdone, (w_step == '0) && m_axis_tlast && (w_len != '0), "row-end hole run malformed")

    // an interpolated hole run is always followed by its pixel, never row-ending
    `DRHI_ASSERT_NOW(a_hole_mid, i_clk, i_rst_n, m_axis_tvalid && w_hole && !m_axis_tlast, !w_rdone && (w_len != '0), "interior hole run malformed")

endmodule

bind depth_row_hole_interpolator drhi_chk u_drhi_chk (.*);
